// ===== hw/rtl/sdas_pkg.sv =====
// shared constants, types and table builders for the scaled decimal add/sub/mul block
// no dependencies; used by every module under hw/rtl

package sdas_pkg;

    // field widths
    localparam int COEFF_WIDTH = 64;
    localparam int EXP_WIDTH   = 8;

    // multiplier split into half-width partial products
    localparam int HALF_WIDTH = (COEFF_WIDTH + 1) / 2;
    localparam int MAG_WIDTH  = 2 * HALF_WIDTH;
    localparam int PROD_WIDTH = 2 * MAG_WIDTH;

    // coefficient range limits as magnitudes
    localparam logic [COEFF_WIDTH-1:0] COEFF_MAX     = {1'b0, {(COEFF_WIDTH-1){1'b1}}};
    localparam logic [COEFF_WIDTH-1:0] COEFF_MIN_MAG = {1'b1, {(COEFF_WIDTH-1){1'b0}}};

    // headroom for building powers of ten at elaboration
    localparam int WIDE_WIDTH = COEFF_WIDTH + 4;

    // largest n with 10^n still inside the positive coefficient range
    function automatic int calc_max_scale();
        logic [WIDE_WIDTH-1:0] p;
        int                    n;
        p = WIDE_WIDTH'(1);
        n = 0;
        for (int i = 0; i < COEFF_WIDTH; i++) begin
            if (WIDE_WIDTH'(p * 10) <= WIDE_WIDTH'(COEFF_MAX)) begin
                p = WIDE_WIDTH'(p * 10);
                n = n + 1;
            end
        end
        return n;
    endfunction

    localparam int MAX_SCALE   = calc_max_scale();
    localparam int SCALE_WIDTH = $clog2(MAX_SCALE + 1);
    localparam int DIST_WIDTH  = (EXP_WIDTH > SCALE_WIDTH) ? EXP_WIDTH : SCALE_WIDTH;

    // constant table of powers of ten, 10^0 .. 10^MAX_SCALE
    typedef logic [MAX_SCALE:0][COEFF_WIDTH-1:0] t_pow_table;

    function automatic t_pow_table calc_pow10();
        t_pow_table                t;
        logic [COEFF_WIDTH-1:0]    p;
        p = COEFF_WIDTH'(1);
        for (int i = 0; i <= MAX_SCALE; i++) begin
            t[i] = p;
            p    = COEFF_WIDTH'(p * 10);
        end
        return t;
    endfunction

    localparam t_pow_table POW10 = calc_pow10();

    // operation codes; code 3 is unused and reports overflow
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2
    } t_opcode;

    // operand data that rides alongside the multiplier
    typedef struct packed {
        logic [1:0]             op;
        logic                   fail;
        logic                   a_scaled;
        logic [COEFF_WIDTH-1:0] other;
        logic [EXP_WIDTH-1:0]   exp;
    } t_side;

    // decoded word handed to the multiplier
    typedef struct packed {
        t_side                  side;
        logic                   neg;
        logic [COEFF_WIDTH-1:0] mag_x;
        logic [COEFF_WIDTH-1:0] mag_y;
    } t_dec;

    // signed, range-checked product
    typedef struct packed {
        t_side                  side;
        logic                   ovf;
        logic [COEFF_WIDTH-1:0] value;
    } t_scaled;

    // unsigned magnitude of a two's complement coefficient
    function automatic logic [COEFF_WIDTH-1:0] magnitude(input logic [COEFF_WIDTH-1:0] c);
        return c[COEFF_WIDTH-1] ? (~c + COEFF_WIDTH'(1)) : c;
    endfunction

endpackage

// ===== hw/rtl/sdas_decode.sv =====
// input register and operand decode: picks the operand to scale and the multiplier inputs
// depends on sdas_pkg

module sdas_decode (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [1:0]                        i_op,
    input  logic [sdas_pkg::COEFF_WIDTH-1:0]  i_a_coef,
    input  logic [sdas_pkg::EXP_WIDTH-1:0]    i_a_exp,
    input  logic [sdas_pkg::COEFF_WIDTH-1:0]  i_b_coef,
    input  logic [sdas_pkg::EXP_WIDTH-1:0]    i_b_exp,
    output logic                              o_valid,
    output sdas_pkg::t_dec                    o_dec
);

    localparam int W  = sdas_pkg::COEFF_WIDTH;
    localparam int E  = sdas_pkg::EXP_WIDTH;
    localparam int SW = sdas_pkg::SCALE_WIDTH;
    localparam int DW = sdas_pkg::DIST_WIDTH;

    logic         r_in_valid;
    logic [1:0]   r_op;
    logic [W-1:0] r_a_coef;
    logic [E-1:0] r_a_exp;
    logic [W-1:0] r_b_coef;
    logic [E-1:0] r_b_exp;

    logic           r_dec_valid;
    sdas_pkg::t_dec r_dec;
    sdas_pkg::t_dec n_dec;

    logic [E:0]    diff;
    logic [E:0]    diff_abs;
    logic          a_gt;
    logic [DW-1:0] dist_ext;
    logic          too_far;
    logic [SW-1:0] scale_idx;
    logic [W-1:0]  mag_a;
    logic [W-1:0]  mag_b;
    logic [W-1:0]  scl_coef;
    logic [E:0]    exp_sum;

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_dec_valid <= 1'b0;
        end else begin
            r_in_valid  <= i_valid;
            r_dec_valid <= r_in_valid;
        end
    end

    // input and decode payload
    always_ff @(posedge i_clk) begin
        r_op     <= i_op;
        r_a_coef <= i_a_coef;
        r_a_exp  <= i_a_exp;
        r_b_coef <= i_b_coef;
        r_b_exp  <= i_b_exp;
        r_dec    <= n_dec;
    end

    // exponent distance and which side gets scaled
    always_comb begin
        diff      = {r_a_exp[E-1], r_a_exp} - {r_b_exp[E-1], r_b_exp};
        a_gt      = $signed(r_a_exp) > $signed(r_b_exp);
        diff_abs  = a_gt ? diff : -diff;
        dist_ext  = DW'(diff_abs[E-1:0]);
        too_far   = dist_ext > DW'(sdas_pkg::MAX_SCALE);
        scale_idx = too_far ? SW'(sdas_pkg::MAX_SCALE) : dist_ext[SW-1:0];
        mag_a     = sdas_pkg::magnitude(r_a_coef);
        mag_b     = sdas_pkg::magnitude(r_b_coef);
        scl_coef  = a_gt ? r_a_coef : r_b_coef;
        exp_sum   = {r_a_exp[E-1], r_a_exp} + {r_b_exp[E-1], r_b_exp};
    end

    // multiplier operands per operation
    always_comb begin
        n_dec               = '0;
        n_dec.side.op       = r_op;
        n_dec.side.a_scaled = a_gt;
        n_dec.side.other    = a_gt ? r_b_coef : r_a_coef;
        unique case (r_op) inside
            sdas_pkg::OP_ADD, sdas_pkg::OP_SUB: begin
                // larger-exponent side times 10^distance
                n_dec.mag_x     = a_gt ? mag_a : mag_b;
                n_dec.mag_y     = sdas_pkg::POW10[scale_idx];
                n_dec.neg       = scl_coef[W-1];
                n_dec.side.fail = too_far && (scl_coef != '0);
                n_dec.side.exp  = a_gt ? r_b_exp : r_a_exp;
            end
            sdas_pkg::OP_MUL: begin
                n_dec.mag_x     = mag_a;
                n_dec.mag_y     = mag_b;
                n_dec.neg       = r_a_coef[W-1] ^ r_b_coef[W-1];
                n_dec.side.fail = exp_sum[E] != exp_sum[E-1];
                n_dec.side.exp  = exp_sum[E-1:0];
            end
            default: begin
                n_dec.side.fail = 1'b1;
            end
        endcase
    end

    assign o_valid = r_dec_valid;
    assign o_dec   = r_dec;

endmodule

// ===== hw/rtl/sdas_mul.sv =====
// four-stage checked magnitude multiplier built from half-width partial products
// depends on sdas_pkg

module sdas_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  sdas_pkg::t_dec    i_dec,
    output logic              o_valid,
    output sdas_pkg::t_scaled o_scaled
);

    localparam int W  = sdas_pkg::COEFF_WIDTH;
    localparam int H  = sdas_pkg::HALF_WIDTH;
    localparam int MW = sdas_pkg::MAG_WIDTH;
    localparam int PW = sdas_pkg::PROD_WIDTH;

    logic [MW-1:0] mx;
    logic [MW-1:0] my;

    // stage valid bits
    logic r_v_pp;
    logic r_v_mid;
    logic r_v_prod;
    logic r_v_out;

    // partial products
    logic [MW-1:0]   r_ll;
    logic [MW-1:0]   r_lh;
    logic [MW-1:0]   r_hl;
    logic [MW-1:0]   r_hh;
    logic            r_neg_pp;
    sdas_pkg::t_side r_side_pp;

    // cross terms summed
    logic [MW:0]     r_mid;
    logic [MW-1:0]   r_ll_mid;
    logic [MW-1:0]   r_hh_mid;
    logic            r_neg_mid;
    sdas_pkg::t_side r_side_mid;

    // full product
    logic [PW-1:0]   r_prod;
    logic            r_neg_prod;
    sdas_pkg::t_side r_side_prod;

    sdas_pkg::t_scaled r_out;
    sdas_pkg::t_scaled n_out;

    logic [W-1:0] lim;
    logic [W-1:0] low;

    assign mx = MW'(i_dec.mag_x);
    assign my = MW'(i_dec.mag_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_pp   <= 1'b0;
            r_v_mid  <= 1'b0;
            r_v_prod <= 1'b0;
            r_v_out  <= 1'b0;
        end else begin
            r_v_pp   <= i_valid;
            r_v_mid  <= r_v_pp;
            r_v_prod <= r_v_mid;
            r_v_out  <= r_v_prod;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        // half by half products
        r_ll      <= {{H{1'b0}}, mx[H-1:0]}  * {{H{1'b0}}, my[H-1:0]};
        r_lh      <= {{H{1'b0}}, mx[H-1:0]}  * {{H{1'b0}}, my[MW-1:H]};
        r_hl      <= {{H{1'b0}}, mx[MW-1:H]} * {{H{1'b0}}, my[H-1:0]};
        r_hh      <= {{H{1'b0}}, mx[MW-1:H]} * {{H{1'b0}}, my[MW-1:H]};
        r_neg_pp  <= i_dec.neg;
        r_side_pp <= i_dec.side;

        // cross terms
        r_mid      <= {1'b0, r_lh} + {1'b0, r_hl};
        r_ll_mid   <= r_ll;
        r_hh_mid   <= r_hh;
        r_neg_mid  <= r_neg_pp;
        r_side_mid <= r_side_pp;

        // assemble
        r_prod      <= {r_hh_mid, r_ll_mid} + (PW'(r_mid) << H);
        r_neg_prod  <= r_neg_mid;
        r_side_prod <= r_side_mid;

        r_out <= n_out;
    end

    // range check against the signed limit and apply sign
    always_comb begin
        lim         = r_neg_prod ? sdas_pkg::COEFF_MIN_MAG : sdas_pkg::COEFF_MAX;
        low         = r_prod[W-1:0];
        n_out.side  = r_side_prod;
        n_out.ovf   = (|r_prod[PW-1:W]) || (low > lim);
        n_out.value = r_neg_prod ? (~low + W'(1)) : low;
    end

    assign o_valid  = r_v_out;
    assign o_scaled = r_out;

    // a zero factor always gives an in-range zero at the output
    a_zero_factor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_dec.mag_x == '0 || i_dec.mag_y == '0)
        |-> ##4 (o_valid && !o_scaled.ovf && o_scaled.value == '0))
        else $error("zero factor did not give zero product");

    // valid moves through all four stages without loss
    a_valid_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ##4 o_valid)
        else $error("multiplier lost a word");

    // a product that fits needs no bits above the coefficient width
    a_fit_high_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v_out && !r_out.ovf |-> $past(r_prod[PW-1:W]) == '0)
        else $error("in-range product had high bits set");

endmodule

// ===== hw/rtl/sdas_addsub.sv =====
// final add or subtract (or product pass-through) with range check, error zeroing and the result register
// depends on sdas_pkg

module sdas_addsub (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  sdas_pkg::t_scaled                i_scaled,
    output logic                             o_strobe,
    output logic [sdas_pkg::COEFF_WIDTH-1:0] o_coef,
    output logic [sdas_pkg::EXP_WIDTH-1:0]   o_exp,
    output logic                             o_ovf
);

    localparam int W = sdas_pkg::COEFF_WIDTH;
    localparam int E = sdas_pkg::EXP_WIDTH;

    logic         r_strobe;
    logic [W-1:0] r_coef;
    logic [E-1:0] r_exp;
    logic         r_ovf;

    logic [W-1:0] n_coef;
    logic [E-1:0] n_exp;
    logic         n_ovf;

    logic [W-1:0] x;
    logic [W-1:0] y;
    logic [W:0]   sum;
    logic [W:0]   dif;
    logic [W-1:0] res;
    logic         err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_coef <= n_coef;
        r_exp  <= n_exp;
        r_ovf  <= n_ovf;
    end

    // operands back in a-then-b order
    always_comb begin
        x   = i_scaled.side.a_scaled ? i_scaled.value : i_scaled.side.other;
        y   = i_scaled.side.a_scaled ? i_scaled.side.other : i_scaled.value;
        sum = {x[W-1], x} + {y[W-1], y};
        dif = {x[W-1], x} - {y[W-1], y};
    end

    // pick result per operation
    always_comb begin
        res = '0;
        err = 1'b0;
        case (i_scaled.side.op) inside
            sdas_pkg::OP_ADD: begin
                res = sum[W-1:0];
                err = sum[W] != sum[W-1];
            end
            sdas_pkg::OP_SUB: begin
                res = dif[W-1:0];
                err = dif[W] != dif[W-1];
            end
            sdas_pkg::OP_MUL: begin
                res = i_scaled.value;
            end
            default: begin
                err = 1'b1;
            end
        endcase
        n_ovf  = i_scaled.side.fail || i_scaled.ovf || err;
        n_coef = n_ovf ? '0 : res;
        n_exp  = n_ovf ? '0 : i_scaled.side.exp;
    end

    assign o_strobe = r_strobe;
    assign o_coef   = r_coef;
    assign o_exp    = r_exp;
    assign o_ovf    = r_ovf;

endmodule

// ===== hw/rtl/scaled_decimal_add_sub_mul.sv =====
// top level of the scaled decimal add/sub/mul unit
// depends on sdas_pkg, sdas_decode, sdas_mul, sdas_addsub

// Takes one word per clock: pulse start with the operands and the result comes
// back on o_strobe after the input, decode, multiplier and result registers,
// one result per word, in order. busy is held low; the unit is a fixed-depth
// pipeline with no stall path, so the receiver must take every result in the
// cycle it is strobed. The multiplier builds each product from four half-width
// partial products over four registered steps; add and subtract use the same
// multiplier to scale the operand with the larger exponent by a power of ten
// from a constant table. Overflow of any step returns zero fields.

module scaled_decimal_add_sub_mul (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic [1:0]                              i_opcode,
    input  logic signed [sdas_pkg::COEFF_WIDTH-1:0] i_a_coefficient,
    input  logic signed [sdas_pkg::EXP_WIDTH-1:0]   i_a_exponent,
    input  logic signed [sdas_pkg::COEFF_WIDTH-1:0] i_b_coefficient,
    input  logic signed [sdas_pkg::EXP_WIDTH-1:0]   i_b_exponent,
    output logic                                    o_strobe,
    output logic signed [sdas_pkg::COEFF_WIDTH-1:0] o_result_coefficient,
    output logic signed [sdas_pkg::EXP_WIDTH-1:0]   o_result_exponent,
    output logic                                    o_overflow
);

    localparam int LATENCY = 7;

    logic              dec_valid;
    sdas_pkg::t_dec    dec;
    logic              scl_valid;
    sdas_pkg::t_scaled scl;

    logic [sdas_pkg::COEFF_WIDTH-1:0] res_coef;
    logic [sdas_pkg::EXP_WIDTH-1:0]   res_exp;

    // never stalls
    assign busy = 1'b0;

    // input register and decode
    sdas_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start),
        .i_op     (i_opcode),
        .i_a_coef (i_a_coefficient),
        .i_a_exp  (i_a_exponent),
        .i_b_coef (i_b_coefficient),
        .i_b_exp  (i_b_exponent),
        .o_valid  (dec_valid),
        .o_dec    (dec)
    );

    // scaling or product
    sdas_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (dec_valid),
        .i_dec    (dec),
        .o_valid  (scl_valid),
        .o_scaled (scl)
    );

    // sum or difference and result register
    sdas_addsub u_addsub (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (scl_valid),
        .i_scaled (scl),
        .o_strobe (o_strobe),
        .o_coef   (res_coef),
        .o_exp    (res_exp),
        .o_ovf    (o_overflow)
    );

    assign o_result_coefficient = res_coef;
    assign o_result_exponent    = res_exp;

    // every accepted word comes out after the fixed pipeline depth
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LATENCY o_strobe)
        else $error("result missing after pipeline depth");

    // no result without a word accepted earlier
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !start |-> ##LATENCY !o_strobe)
        else $error("result strobed without an accepted word");

    // overflow results carry zero fields
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_overflow |-> (res_coef == '0 && res_exp == '0))
        else $error("overflow result not zeroed");

endmodule
